### rtl/core/sorted_list_insert_remove_defines.svh
// Assertion macros for the sorted list block.
`ifndef SORTED_LIST_INSERT_REMOVE_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SLI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define SLI_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### rtl/core/sli_pkg.sv
// Types and constants shared by the sorted list cells and the top level.
`timescale 1ns / 1ps

package sli_pkg;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned ST_W     = 2;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned IN_TD_W  = 40;
    localparam int unsigned OUT_TD_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_POS   = 2'd3
    } t_status;

    // Shift commands broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

### rtl/core/sli_cell.sv
// One storage cell of the sorted list: holds an entry, compares it with the key, shifts.
`timescale 1ns / 1ps

module sli_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 5
) (
    input  logic                           i_clk,
    input  sli_pkg::t_cell_ctl             i_ctl,
    input  logic signed [sli_pkg::KEY_W-1:0] i_key,
    input  logic [CW-1:0]                  i_count,
    input  logic signed [sli_pkg::KEY_W-1:0] i_left_value,
    input  logic                           i_left_lt,
    input  logic signed [sli_pkg::KEY_W-1:0] i_right_value,
    output logic signed [sli_pkg::KEY_W-1:0] o_value,
    output logic                           o_lt,
    output logic                           o_first,
    output logic                           o_hit
);
    import sli_pkg::*;

    logic signed [KEY_W-1:0] r_value;
    logic signed [KEY_W-1:0] n_value;
    logic                    occupied;

    assign occupied = (32'(i_count) > IDX);
    assign o_lt     = occupied && (r_value < i_key);
    // first cell not below the key: insert point, and first candidate for a match
    assign o_first  = !o_lt && i_left_lt;
    assign o_hit    = o_first && occupied && (r_value == i_key);
    assign o_value  = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins && !o_lt) begin
            n_value = i_left_lt ? i_key : i_left_value;
        end else if (i_ctl.rem && !o_lt) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

### rtl/core/sorted_list_insert_remove.sv
// Sorted list of signed values as a chain of compare-and-shift cells.
// Results are registered; one item per cycle sustained while results are taken.
// Every cell compares with the broadcast key and shifts in the same cycle.
// A result register decouples the sides: input ready while the result is empty or taken.
// Reset (i_rst_n low, synchronous) empties the list and the result register.
`timescale 1ns / 1ps

`include "sorted_list_insert_remove_defines.svh"

module sorted_list_insert_remove #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] key_value, [35:32] read_position, rest zero
    input  logic [sli_pkg::IN_TD_W-1:0]      s_axis_tdata,
    // [1:0] opcode
    input  logic [sli_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] result_value, [35:32] slot, [40:36] entry_count, rest zero
    output logic [sli_pkg::OUT_TD_W-1:0]     m_axis_tdata,
    // [1:0] status
    output logic [sli_pkg::ST_W-1:0]         m_axis_tuser
);
    import sli_pkg::*;

    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                    accept;
    t_opcode                 op;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        rpos;
    t_cell_ctl               ctl;

    logic signed [KEY_W-1:0] cell_value [CAPACITY];
    logic                    cell_lt    [CAPACITY];
    logic                    cell_first [CAPACITY];
    logic                    cell_hit   [CAPACITY];

    logic                    full;
    logic                    found;
    logic [SLOT_W-1:0]       ins_slot;
    logic                    rpos_ok;
    logic signed [KEY_W-1:0] read_value;

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_out_valid;
    t_status                 r_status;
    t_status                 n_status;
    logic signed [KEY_W-1:0] r_value;
    logic signed [KEY_W-1:0] n_value;
    logic [SLOT_W-1:0]       r_slot;
    logic [SLOT_W-1:0]       n_slot;
    logic [CNT_W-1:0]        r_out_count;

    // hold off input items while reset is applied
    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = t_opcode'(s_axis_tuser);
    assign key           = s_axis_tdata[KEY_W-1:0];
    assign rpos          = s_axis_tdata[KEY_W+POS_W-1:KEY_W];

    assign full    = (32'(r_count) >= CAPACITY);
    assign ctl.ins = accept && (op == OP_INSERT) && !full;
    assign ctl.rem = accept && (op == OP_REMOVE) && found;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] left_value;
        logic                    left_lt;
        logic signed [KEY_W-1:0] right_value;

        if (g == 0) begin : g_head
            assign left_value = key;
            assign left_lt    = 1'b1;
        end else begin : g_body
            assign left_value = cell_value[g-1];
            assign left_lt    = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_value = cell_value[g];
        end else begin : g_mid
            assign right_value = cell_value[g+1];
        end

        sli_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_key         (key),
            .i_count       (r_count),
            .i_left_value  (left_value),
            .i_left_lt     (left_lt),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g]),
            .o_first       (cell_first[g]),
            .o_hit         (cell_hit[g])
        );
    end

    // The insert point marks at most one cell; fold its index and the match flag.
    always_comb begin
        ins_slot = '0;
        found    = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_first[i]) begin
                ins_slot = ins_slot | SLOT_W'(i);
            end
            found = found | cell_hit[i];
        end
    end

    assign rpos_ok    = (32'(rpos) < 32'(r_count));
    assign read_value = cell_value[IW'(rpos)];

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_value  = '0;
        n_slot   = '0;
        unique case (op)
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    n_value = key;
                    n_slot  = ins_slot;
                end
            end
            OP_REMOVE: begin
                if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_count = r_count - CW'(1);
                    n_value = key;
                    n_slot  = ins_slot;
                end
            end
            OP_READ: begin
                if (!rpos_ok) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_value = read_value;
                    n_slot  = SLOT_W'(rpos);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result payload until the next item is accepted
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_value     <= n_value;
            r_slot      <= n_slot;
            r_out_count <= CNT_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {(OUT_TD_W - KEY_W - SLOT_W - CNT_W)'(0), r_out_count, r_slot,
                            r_value};

    `SLI_ASSERT_ALWAYS(a_count_bound, 32'(r_count) <= CAPACITY, "count beyond capacity")
    `SLI_ASSERT_NEXT(a_insert_grows, ctl.ins, r_count == $past(r_count) + CW'(1), "insert count")
    `SLI_ASSERT_NEXT(a_miss_keeps, accept && op == OP_REMOVE && !found, $stable(r_count), "miss")
    `SLI_ASSERT_NEXT(a_accept_result, accept, r_out_valid, "accepted item gave no result")

endmodule

### test/tb_sorted_list_insert_remove.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted list block: queued stream items, predicted table, checks.
module tb_sorted_list_insert_remove;
    import sli_pkg::*;

    localparam int unsigned CAPACITY      = 16;
    localparam int unsigned RANDOM_OPS    = 1524;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_PRINTS    = 50;

    typedef struct {
        t_opcode     op;
        logic [31:0] key;
        logic [3:0]  pos;
        bit          drain;   // wait for all results before sending this item
    } t_list_op;

    typedef struct {
        t_status     status;
        logic [31:0] value;
        logic [3:0]  slot;
        logic [4:0]  count;
    } t_list_result;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_TD_W-1:0]  s_axis_tdata  = '0;
    logic [OP_W-1:0]     s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_TD_W-1:0] m_axis_tdata;
    logic [ST_W-1:0]     m_axis_tuser;

    sorted_list_insert_remove #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Predicted contents of the list, ascending.
    logic signed [31:0] list_vals [CAPACITY];
    int unsigned        list_len = 0;

    t_list_op     pending_ops [$];
    t_list_result expected_results [$];

    int unsigned sent_count  = 0;
    int unsigned recv_count  = 0;
    int unsigned total_ops   = 0;
    int unsigned error_count = 0;
    int unsigned status_seen [4] = '{default: 0};

    function automatic t_list_result apply_list_op(t_list_op it);
        t_list_result r;
        int unsigned  p;
        r.status = ST_OK;
        r.value  = '0;
        r.slot   = '0;
        case (it.op)
            OP_INSERT: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    p = 0;
                    while (p < list_len && list_vals[p] < $signed(it.key))
                        p++;
                    for (int unsigned i = list_len; i > p; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[p] = it.key;
                    list_len++;
                    r.value = it.key;
                    r.slot  = p[3:0];
                end
            end
            OP_REMOVE: begin
                p = 0;
                while (p < list_len && list_vals[p] != it.key)
                    p++;
                if (p >= list_len) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int unsigned i = p; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i + 1];
                    list_len--;
                    r.value = it.key;
                    r.slot  = p[3:0];
                end
            end
            OP_READ: begin
                if (it.pos >= list_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.value = list_vals[it.pos];
                    r.slot  = it.pos;
                end
            end
            default: ;
        endcase
        r.count = list_len[4:0];
        return r;
    endfunction

    function automatic t_list_op make_op(t_opcode op, logic [31:0] key, logic [3:0] pos,
                                         bit drain);
        t_list_op it;
        it.op    = op;
        it.key   = key;
        it.pos   = pos;
        it.drain = drain;
        return it;
    endfunction

    // Mostly a small pool so removes hit and duplicates pile up.
    function automatic logic [31:0] pick_key();
        logic [31:0] pool [12] = '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0,
                                   32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'd100,
                                   32'hFFFF_FF9C, 32'd7, 32'h5555_5555, 32'hAAAA_AAAA};
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return pool[$urandom_range(0, 11)];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < MAX_PRINTS)
            $display("ERROR: result %0d %s: got %0h, expected %0h", recv_count, what, got, want);
        error_count++;
    endtask

    // Sender: bursts of random length, random gaps in between.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    t_list_op    cur_op;

    always @(posedge i_clk) begin
        bit accepted;
        bit busy;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            accepted = s_axis_tvalid && s_axis_tready;
            busy     = s_axis_tvalid && !accepted;
            if (accepted) begin
                expected_results.push_back(apply_list_op(cur_op));
                sent_count <= sent_count + 1;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_ops.size() > 0 &&
                             !(pending_ops[0].drain && (accepted || sent_count != recv_count))) begin
                    cur_op = pending_ops.pop_front();
                    s_axis_tdata <= {{(IN_TD_W - 36){1'b0}}, cur_op.pos, cur_op.key};
                    s_axis_tuser <= cur_op.op;
                    busy = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 11);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_axis_tvalid <= busy;
        end
    end

    // Receiver: check each result and stall on a slowly rotating pattern.
    int unsigned rx_cycle   = 0;
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (recv_count >= sent_count) begin
                    report_mismatch("with no item pending", m_axis_tdata[31:0], 32'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser != want.status)
                        report_mismatch("status", m_axis_tuser, want.status);
                    if (m_axis_tdata[31:0] != want.value)
                        report_mismatch("value", m_axis_tdata[31:0], want.value);
                    if (m_axis_tdata[35:32] != want.slot)
                        report_mismatch("slot", m_axis_tdata[35:32], want.slot);
                    if (m_axis_tdata[40:36] != want.count)
                        report_mismatch("count", m_axis_tdata[40:36], want.count);
                    status_seen[want.status]++;
                    recv_count <= recv_count + 1;
                end
            end
            rx_cycle = rx_cycle + 1;
            case (rx_cycle[9:8])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_axis_tready <= 1'b0;
                    end else begin
                        stall_left = $urandom_range(0, 7);
                        m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // End the run if neither side moves an item for too long.
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [31:0] fill_vals [16] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0,
                                        32'hFFFF_FFFF, 32'h1, 32'h5555_5555, 32'hAAAA_AAAA,
                                        32'd100, 32'hFFFF_FF9C, 32'd7, 32'd7,
                                        32'h0000_1000, 32'hF000_0000, 32'h0FFF_FFFF,
                                        32'h8000_0001};
        int unsigned directed_ops;
        int unsigned n_rand;
        int unsigned phase_len;
        int unsigned roll;
        int unsigned ins_w;
        int unsigned rem_w;
        bit          first_phase;
        t_opcode     op;

        // Empty table: read and remove both fail, unused opcode does nothing.
        pending_ops.push_back(make_op(OP_READ, 32'h0, 4'd0, 1'b0));
        pending_ops.push_back(make_op(OP_REMOVE, 32'h0, 4'd0, 1'b0));
        pending_ops.push_back(make_op(OP_NOP, 32'hFFFF_FFFF, 4'hF, 1'b0));
        // Fill to capacity with extremes and duplicates, then overflow.
        foreach (fill_vals[i])
            pending_ops.push_back(make_op(OP_INSERT, fill_vals[i], 4'(i), 1'b0));
        pending_ops.push_back(make_op(OP_INSERT, 32'd7, 4'd0, 1'b0));
        pending_ops.push_back(make_op(OP_READ, 32'h0, 4'd15, 1'b0));
        // Remove the head, a missing value and the tail.
        pending_ops.push_back(make_op(OP_REMOVE, 32'h8000_0000, 4'd0, 1'b0));
        pending_ops.push_back(make_op(OP_REMOVE, 32'd12345, 4'd0, 1'b0));
        pending_ops.push_back(make_op(OP_REMOVE, 32'h7FFF_FFFF, 4'd0, 1'b0));
        pending_ops.push_back(make_op(OP_READ, 32'h0, 4'd14, 1'b0));
        pending_ops.push_back(make_op(OP_READ, 32'h0, 4'd0, 1'b0));
        directed_ops = pending_ops.size();

        // Random phases lean toward filling, draining or a balanced mix.
        n_rand      = 0;
        first_phase = 1'b1;
        while (n_rand < RANDOM_OPS) begin
            phase_len = $urandom_range(40, 120);
            case ($urandom_range(0, 2))
                0: begin ins_w = 65; rem_w = 80; end
                1: begin ins_w = 20; rem_w = 75; end
                default: begin ins_w = 38; rem_w = 70; end
            endcase
            for (int k = 0; k < phase_len && n_rand < RANDOM_OPS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_w)
                    op = OP_INSERT;
                else if (roll < rem_w)
                    op = OP_REMOVE;
                else if (roll < 98)
                    op = OP_READ;
                else
                    op = OP_NOP;
                pending_ops.push_back(make_op(op, pick_key(), 4'($urandom_range(0, 15)),
                    k == 0 && (first_phase || $urandom_range(0, 3) == 0)));
                n_rand++;
            end
            first_phase = 1'b0;
        end
        total_ops = pending_ops.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (recv_count != total_ops)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("left over at end", expected_results.size(), 32'h0);

        $display("Covered %0d items (%0d directed) under random sender gaps and receiver stalls.",
                 total_ops, directed_ops);
        $display("Statuses seen: ok %0d, full %0d, not found %0d, bad position %0d.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
                 status_seen[ST_BAD_POS]);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sli_pkg.sv
rtl/core/sli_cell.sv
rtl/core/sorted_list_insert_remove.sv
test/tb_sorted_list_insert_remove.sv
